@@ sv/bmds_pkg.sv @@
// bmds_pkg: shared types and constants for the bcd display scan core
// holds the queue word type and the power-of-ten table; no dependencies
package bmds_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned WIDE_W  = 34;  // holds 9 * 10^9 and 10^10

  // powers of ten, 10^0 up to 10^10
  localparam logic [WIDE_W-1:0] POW10 [0:10] = '{
    34'd1,
    34'd10,
    34'd100,
    34'd1000,
    34'd10000,
    34'd100000,
    34'd1000000,
    34'd10000000,
    34'd100000000,
    34'd1000000000,
    34'd10000000000
  };

  // word passed from the front part to the back part
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [DIGIT_W-1:0] top_k;  // power of ten of the first digit shown
    logic               ovf;
  } bmds_item_t;

endpackage

@@ sv/bcd_multiplexed_display_scan_core.sv @@
// bcd_multiplexed_display_scan_core: top level of the bcd display scan core
// depends on bmds_pkg, bmds_front, bmds_queue and bmds_back
//
// Each value pushed in is shown as digits_in_use decimal digits (clamped to
// 1..MAX_DIGITS, reset 3), most significant first with leading zeros kept: one
// word per display position carrying the position and its bcd code, the final
// one marked last. A value of at least ten to the digit count gives one word
// with overflow and last set instead. The front part clamps the count and
// classifies the value as it is pushed; a two-entry queue feeds the back
// part, whose digit unit produces one digit per cycle while the output is
// not held by a missing pop, and the next value follows with no gap. The
// output register takes a new word in the cycle the old one is popped. No
// clearing pass follows reset.
module bcd_multiplexed_display_scan_core #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bmds_pkg::DIGIT_W-1:0] cfg_digits_in_use,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [bmds_pkg::VALUE_W-1:0] in_value,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [bmds_pkg::DIGIT_W-1:0] out_digit_position,
  output logic [bmds_pkg::DIGIT_W-1:0] out_bcd_digit,
  output logic                         out_overflow,
  output logic                         out_last
);
  import bmds_pkg::*;

  bmds_item_t front_item;
  bmds_item_t q_head;
  logic       q_empty, q_rd;

  bmds_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_digits_in_use(cfg_digits_in_use),
    .in_value         (in_value),
    .item             (front_item)
  );

  bmds_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (in_push),
    .wr_item(front_item),
    .rd     (q_rd),
    .full   (in_full),
    .empty  (q_empty),
    .head   (q_head)
  );

  bmds_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .q_rd              (q_rd),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_digit_position(out_digit_position),
    .out_bcd_digit     (out_bcd_digit),
    .out_overflow      (out_overflow),
    .out_last          (out_last)
  );

endmodule

@@ sv/bmds_front.sv @@
// bmds_front: digit count register, clamping and overflow classification
// depends on bmds_pkg
module bmds_front #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bmds_pkg::DIGIT_W-1:0] cfg_digits_in_use,
  input  logic [bmds_pkg::VALUE_W-1:0] in_value,
  output bmds_pkg::bmds_item_t         item
);
  import bmds_pkg::*;

  localparam logic [DIGIT_W-1:0] MaxDig = DIGIT_W'(MAX_DIGITS);

  logic [DIGIT_W-1:0] digits_r, digits_nxt;
  logic [DIGIT_W-1:0] n_eff;

  assign cfg_ready = 1'b1;

  always_comb begin
    digits_nxt = digits_r;
    if (cfg_valid) begin
      digits_nxt = cfg_digits_in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r <= 4'd3;
    end else begin
      digits_r <= digits_nxt;
    end
  end

  always_comb begin
    if (digits_r == '0) begin
      n_eff = DIGIT_W'(1);
    end else if (digits_r > MaxDig) begin
      n_eff = MaxDig;
    end else begin
      n_eff = digits_r;
    end
  end

  // value too large when it reaches 10^n
  always_comb begin
    item.value = in_value;
    item.top_k = n_eff - DIGIT_W'(1);
    item.ovf   = ({2'b00, in_value} >= POW10[n_eff]);
  end

endmodule

@@ sv/bmds_queue.sv @@
// bmds_queue: two-entry queue between the front and back parts
// depends on bmds_pkg
module bmds_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr,
  input  bmds_pkg::bmds_item_t wr_item,
  input  logic                 rd,
  output logic                 full,
  output logic                 empty,
  output bmds_pkg::bmds_item_t head
);
  import bmds_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);

  bmds_item_t          mem_r [Depth];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [PtrW:0]       count_r, count_nxt;
  logic                do_wr, do_rd;

  assign full  = (count_r == (PtrW+1)'(Depth));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = wr_ptr_r + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = rd_ptr_r + PtrW'(1);
    end
    case ({do_wr, do_rd})
      2'b10:   count_nxt = count_r + (PtrW+1)'(1);
      2'b01:   count_nxt = count_r - (PtrW+1)'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

@@ sv/bmds_back.sv @@
// bmds_back: digit extraction, one decimal digit per cycle unless the output stalls, and output register
// depends on bmds_pkg
module bmds_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  bmds_pkg::bmds_item_t         q_head,
  output logic                         q_rd,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [bmds_pkg::DIGIT_W-1:0] out_digit_position,
  output logic [bmds_pkg::DIGIT_W-1:0] out_bcd_digit,
  output logic                         out_overflow,
  output logic                         out_last
);
  import bmds_pkg::*;

  logic               busy_r, busy_nxt;
  logic [VALUE_W-1:0] rem_r, rem_nxt;
  logic [DIGIT_W-1:0] k_r, k_nxt;
  logic [DIGIT_W-1:0] pos_r, pos_nxt;

  logic               out_vld_r, out_vld_nxt;
  logic [DIGIT_W-1:0] out_pos_r, out_pos_nxt;
  logic [DIGIT_W-1:0] out_bcd_r, out_bcd_nxt;
  logic               out_ovf_r, out_ovf_nxt;
  logic               out_last_r, out_last_nxt;

  logic               adv, take, head_ovf;
  logic [VALUE_W-1:0] src_rem;
  logic [DIGIT_W-1:0] src_k, src_pos, digit;
  logic [WIDE_W-1:0]  mult [0:9];
  logic [8:0]         ge;

  assign adv  = !out_vld_r || out_pop;
  assign take = adv && (busy_r || !q_empty);
  assign q_rd = adv && !busy_r && !q_empty;

  // first digit comes straight from the queue head, later ones from the remainder
  always_comb begin
    src_rem  = busy_r ? rem_r : q_head.value;
    src_k    = busy_r ? k_r : q_head.top_k;
    src_pos  = busy_r ? pos_r : '0;
    head_ovf = !busy_r && q_head.ovf;
  end

  // digit = number of multiples d * 10^k not above the remainder
  always_comb begin
    mult[0] = '0;
    for (int d = 1; d <= 9; d++) begin
      mult[d]   = POW10[src_k] * WIDE_W'(d);
      ge[d-1]   = ({2'b00, src_rem} >= mult[d]);
    end
    digit   = DIGIT_W'($countones(ge));
    rem_nxt = src_rem - mult[digit][VALUE_W-1:0];
  end

  always_comb begin
    busy_nxt     = busy_r;
    k_nxt        = k_r;
    pos_nxt      = pos_r;
    out_vld_nxt  = out_vld_r;
    out_pos_nxt  = out_pos_r;
    out_bcd_nxt  = out_bcd_r;
    out_ovf_nxt  = out_ovf_r;
    out_last_nxt = out_last_r;
    if (take) begin
      out_vld_nxt = 1'b1;
      if (head_ovf) begin
        busy_nxt     = 1'b0;
        out_pos_nxt  = '0;
        out_bcd_nxt  = '0;
        out_ovf_nxt  = 1'b1;
        out_last_nxt = 1'b1;
      end else begin
        busy_nxt     = (src_k != '0);
        k_nxt        = src_k - DIGIT_W'(1);
        pos_nxt      = src_pos + DIGIT_W'(1);
        out_pos_nxt  = src_pos;
        out_bcd_nxt  = digit;
        out_ovf_nxt  = 1'b0;
        out_last_nxt = (src_k == '0);
      end
    end else if (adv) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rem_r <= rem_nxt;
    end
    k_r        <= k_nxt;
    pos_r      <= pos_nxt;
    out_pos_r  <= out_pos_nxt;
    out_bcd_r  <= out_bcd_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_empty          = !out_vld_r;
  assign out_digit_position = out_pos_r;
  assign out_bcd_digit      = out_bcd_r;
  assign out_overflow       = out_ovf_r;
  assign out_last           = out_last_r;

`ifndef SYNTHESIS
  a_ovf_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_ovf_r |-> out_last_r && out_pos_r == '0 && out_bcd_r == '0)
    else $error("overflow word not a lone last word");

  a_bcd_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_bcd_r <= DIGIT_W'(9))
    else $error("bcd digit above nine");

  a_busy_word : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> out_vld_r && !out_last_r && !out_ovf_r)
    else $error("scan in progress after a last word");

  a_no_pop_busy : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !q_rd)
    else $error("queue read during a scan");
`endif

endmodule

@@ sim/tb_top.sv @@
// tb_top: self-checking bench for bcd_multiplexed_display_scan_core
// predicts every display word from the pushed value and the digit count
// depends on bmds_pkg and bcd_multiplexed_display_scan_core
`timescale 1ns / 100ps

module tb_top;
  import bmds_pkg::*;

  localparam int TOP_DIGITS   = 10;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE_TICKS = 24;
  localparam int PHASES       = 10;
  localparam int PHASE_VALUES = 40;

  typedef struct {
    logic [DIGIT_W-1:0] position;
    logic [DIGIT_W-1:0] bcd;
    logic               overflow;
    logic               last;
  } scan_word_t;

  class scan_predictor;
    logic [DIGIT_W-1:0] digit_count;
    scan_word_t         pending_words[$];
    int                 errors;

    function new();
      digit_count = 4'd3;
      errors      = 0;
    endfunction

    // zero counts as one, anything above the maximum as the maximum
    function int shown_digits();
      int n;
      n = digit_count;
      if (n < 1) n = 1;
      if (n > TOP_DIGITS) n = TOP_DIGITS;
      return n;
    endfunction

    function void note_value(logic [VALUE_W-1:0] v);
      int                 n;
      int                 i;
      longint unsigned    limit;
      longint unsigned    rest;
      logic [DIGIT_W-1:0] dig [TOP_DIGITS];
      scan_word_t         w;
      n     = shown_digits();
      limit = 1;
      for (i = 0; i < n; i++) limit = limit * 10;
      if (v >= limit) begin
        w.position = '0;
        w.bcd      = '0;
        w.overflow = 1'b1;
        w.last     = 1'b1;
        pending_words.push_back(w);
        return;
      end
      rest = v;
      for (i = n - 1; i >= 0; i--) begin
        dig[i] = DIGIT_W'(rest % 10);
        rest   = rest / 10;
      end
      for (i = 0; i < n; i++) begin
        w.position = DIGIT_W'(i);
        w.bcd      = dig[i];
        w.overflow = 1'b0;
        w.last     = (i == n - 1);
        pending_words.push_back(w);
      end
    endfunction

    function void flag(string what, scan_word_t want, scan_word_t got);
      errors++;
      if (errors <= 10) begin
        $display("%s: expected pos %0d bcd %0d ovf %0b last %0b",
                 what, want.position, want.bcd, want.overflow, want.last);
        $display("%s: got pos %0d bcd %0d ovf %0b last %0b",
                 what, got.position, got.bcd, got.overflow, got.last);
      end
    endfunction

    function void check_word(scan_word_t got);
      scan_word_t want;
      if (pending_words.size() == 0) begin
        want = '{default: '0};
        flag("word with nothing pending", want, got);
        return;
      end
      want = pending_words.pop_front();
      if (got.position !== want.position || got.bcd !== want.bcd ||
          got.overflow !== want.overflow || got.last !== want.last)
        flag("display word mismatch", want, got);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [DIGIT_W-1:0]   cfg_digits_in_use;
  logic                 in_push;
  logic                 in_full;
  logic [VALUE_W-1:0]   in_value;
  logic                 out_empty;
  logic                 out_pop;
  logic [DIGIT_W-1:0]   out_digit_position;
  logic [DIGIT_W-1:0]   out_bcd_digit;
  logic                 out_overflow;
  logic                 out_last;

  scan_predictor scores;
  bit            idle_on;
  int            quiet;

  bcd_multiplexed_display_scan_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_digits_in_use  (cfg_digits_in_use),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_value           (in_value),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_digit_position (out_digit_position),
    .out_bcd_digit      (out_bcd_digit),
    .out_overflow       (out_overflow),
    .out_last           (out_last)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // push stays high between back-to-back values
  task automatic push_value(input logic [VALUE_W-1:0] v);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push  <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (in_full) @(posedge clk);
    scores.note_value(v);
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    while (scores.pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_digits(input logic [DIGIT_W-1:0] d);
    drain_results();
    cfg_valid         <= 1'b1;
    cfg_digits_in_use <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid          <= 1'b0;
    scores.digit_count = d;
  endtask

  // mostly values that fit, plus the boundary on both sides and raw words
  function automatic logic [VALUE_W-1:0] pick_value(int n);
    longint unsigned limit;
    int              i;
    limit = 1;
    for (i = 0; i < n; i++) limit = limit * 10;
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: return (limit - 1 > 64'hFFFF_FFFF) ? $urandom : VALUE_W'(limit - 1);
      3: return (limit > 64'hFFFF_FFFF) ? $urandom : VALUE_W'(limit);
      default: return VALUE_W'({$urandom, $urandom} % limit);
    endcase
  endfunction

  initial begin : pop_side
    int         stall;
    scan_word_t got;
    stall = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (stall > 0) begin
        stall--;
        out_pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall   = $urandom_range(1, 12) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
      @(posedge clk);
      if (out_pop && !out_empty) begin
        got.position = out_digit_position;
        got.bcd      = out_bcd_digit;
        got.overflow = out_overflow;
        got.last     = out_last;
        scores.check_word(got);
      end
    end
  end

  // cycles with no word moving on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("[bcd_multiplexed_display_scan_core] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int                 phase;
    int                 k;
    logic [DIGIT_W-1:0] d;
    scores            = new();
    idle_on           = 1'b1;
    quiet             = 0;
    rst_n             = 1'b0;
    in_push           = 1'b0;
    in_value          = '0;
    out_pop           = 1'b0;
    cfg_valid         = 1'b0;
    cfg_digits_in_use = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // three digits after reset
    push_value(32'd0);
    push_value(32'd999);
    push_value(32'd1000);
    push_value(32'hFFFF_FFFF);
    push_value(32'd7);
    write_digits(4'd10);
    push_value(32'hFFFF_FFFF);
    push_value(32'd0);
    push_value(32'd1234567890);
    push_value(32'd999999999);
    push_value(32'h8000_0000);
    // zero digits shows one
    write_digits(4'd0);
    push_value(32'd9);
    push_value(32'd10);
    push_value(32'd0);
    // above the maximum shows ten
    write_digits(4'd15);
    push_value(32'hFFFF_FFFF);
    push_value(32'd1);
    write_digits(4'd1);
    push_value(32'd5);
    push_value(32'd10);
    write_digits(4'd9);
    push_value(32'd999999999);
    push_value(32'd1000000000);

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: d = 4'd1;
        1: d = 4'd10;
        2: d = 4'd0;
        3: d = 4'd15;
        default: d = DIGIT_W'($urandom_range(0, 15));
      endcase
      idle_on = (phase < PHASES - 2);
      write_digits(d);
      for (k = 0; k < PHASE_VALUES; k++)
        push_value(pick_value(scores.shown_digits()));
    end

    drain_results();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (scores.errors == 0 && scores.pending_words.size() == 0)
      $display("[bcd_multiplexed_display_scan_core] OK");
    else
      $display("[bcd_multiplexed_display_scan_core] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
sv/bmds_pkg.sv
sv/bmds_front.sv
sv/bmds_queue.sv
sv/bmds_back.sv
sv/bcd_multiplexed_display_scan_core.sv
sim/tb_top.sv
